### design/sfkh_pkg.sv
package sfkh_pkg;

   localparam int unsigned NUM_STAGES = 9;
   localparam int unsigned WORDS_V6 = 10;
   localparam int unsigned WORDS_V4 = 4;

   localparam logic [31:0] HASH_IV = 32'hdeadbeef;
   localparam logic [31:0] FIXED_PORTS = {16'hbeef, 16'hfeed};
   localparam logic [31:0] LEN_BYTES_V4 = 32'(WORDS_V4 << 2);
   localparam logic [31:0] LEN_BYTES_V6 = 32'(WORDS_V6 << 2);

   typedef enum logic [1:0] {
      FORM_NONE       = 2'd0,
      FORM_V4_PORTS   = 2'd1,
      FORM_V4_NOPORTS = 2'd2,
      FORM_V6         = 2'd3
   } key_form_type;

   typedef struct packed {
      logic                             none;
      logic                             v6;
      logic [31:0]                      a;
      logic [31:0]                      b;
      logic [31:0]                      c;
      logic [WORDS_V6-1:0][31:0]        w;
   } stage_type;

   function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned k);
      return (x << k) | (x >> (32 - k));
   endfunction

   // first half of the lookup3 mix, words folded in first
   function automatic stage_type mix_lo(input stage_type s, input logic [31:0] w0,
                                        input logic [31:0] w1, input logic [31:0] w2);
      stage_type r;
      r = s;
      r.a = r.a + w0;
      r.b = r.b + w1;
      r.c = r.c + w2;
      r.a = r.a - r.c; r.a = r.a ^ rotl(r.c, 4);  r.c = r.c + r.b;
      r.b = r.b - r.a; r.b = r.b ^ rotl(r.a, 6);  r.a = r.a + r.c;
      r.c = r.c - r.b; r.c = r.c ^ rotl(r.b, 8);  r.b = r.b + r.a;
      return r;
   endfunction

   function automatic stage_type mix_hi(input stage_type s);
      stage_type r;
      r = s;
      r.a = r.a - r.c; r.a = r.a ^ rotl(r.c, 16); r.c = r.c + r.b;
      r.b = r.b - r.a; r.b = r.b ^ rotl(r.a, 19); r.a = r.a + r.c;
      r.c = r.c - r.b; r.c = r.c ^ rotl(r.b, 4);  r.b = r.b + r.a;
      return r;
   endfunction

   function automatic stage_type fin_lo(input stage_type s, input logic [31:0] wl);
      stage_type r;
      r = s;
      r.a = r.a + wl;
      r.c = r.c ^ r.b; r.c = r.c - rotl(r.b, 14);
      r.a = r.a ^ r.c; r.a = r.a - rotl(r.c, 11);
      r.b = r.b ^ r.a; r.b = r.b - rotl(r.a, 25);
      r.c = r.c ^ r.b; r.c = r.c - rotl(r.b, 16);
      return r;
   endfunction

   function automatic stage_type fin_hi(input stage_type s);
      stage_type r;
      r = s;
      r.a = r.a ^ r.c; r.a = r.a - rotl(r.c, 4);
      r.b = r.b ^ r.a; r.b = r.b - rotl(r.a, 14);
      r.c = r.c ^ r.b; r.c = r.c - rotl(r.b, 24);
      if (r.none) begin
         r.c = '0;
      end
      return r;
   endfunction

endpackage

### design/symmetric_flow_key_hash_top.sv
// Symmetric flow key hash: one parsed header beat in, one 32-bit flow key beat out, the same key
// for both directions of a flow. A new beat can be taken every cycle while rsp is not
// backpressured; each beat passes through the ordering stage, three lookup3 mix rounds of two
// stages each and two final stages, all registered, before rsp_tvalid rises with its key.
// IPv4 beats use one mix round and pass the other two unchanged. Each stage
// holds while the stage after it is full and stalled, so bubbles are squeezed out while rsp is
// backpressured. req_tready is low during reset. Write csr_wdata with csr_wen only while the
// pipeline is empty; the seed applies to beats accepted afterwards.
module symmetric_flow_key_hash_top (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wen,
   input  logic [31:0]  csr_wdata,     // hash_seed
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [1:0]   req_tuser,     // key_form
   // src_word0..3, dst_word0..3, src_port, dst_port, protocol
   input  logic [295:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [31:0]  rsp_tdata      // flow_key
);

   localparam int unsigned LAST = sfkh_pkg::NUM_STAGES - 1;

   logic [31:0]         seed_ff;
   logic [31:0]         seed_in;
   logic [LAST:0]       valid_ff;
   sfkh_pkg::stage_type st_ff [sfkh_pkg::NUM_STAGES];
   sfkh_pkg::stage_type order_in;
   sfkh_pkg::stage_type st_in [1:LAST];
   logic [LAST:0]       adv;

   logic [3:0][31:0] src;
   logic [3:0][31:0] dst;
   logic [15:0]      sp;
   logic [15:0]      dp;
   logic [7:0]       proto;
   logic [31:0]      ports;
   logic             v4_src_first;
   logic             v6_src_first;
   sfkh_pkg::key_form_type form;

   assign seed_in = csr_wen ? csr_wdata : seed_ff;

   always_comb begin
      for (int i = 0; i < 4; i++) begin
         src[i] = req_tdata[32*i +: 32];
         dst[i] = req_tdata[128 + 32*i +: 32];
      end
      sp    = req_tdata[271:256];
      dp    = req_tdata[287:272];
      proto = req_tdata[295:288];
      form  = sfkh_pkg::key_form_type'(req_tuser);
      ports = (sp > dp) ? {dp, sp} : {sp, dp};
      v4_src_first = src[0] > dst[0];
      // word 0 is the most significant for the lexicographic order
      v6_src_first = {src[0], src[1], src[2], src[3]} > {dst[0], dst[1], dst[2], dst[3]};
   end

   // ordering stage
   always_comb begin
      order_in      = '0;
      order_in.none = (form == sfkh_pkg::FORM_NONE);
      order_in.v6   = (form == sfkh_pkg::FORM_V6);
      if (form == sfkh_pkg::FORM_V6) begin
         for (int i = 0; i < 4; i++) begin
            order_in.w[i]     = v6_src_first ? src[i] : dst[i];
            order_in.w[4 + i] = v6_src_first ? dst[i] : src[i];
         end
         order_in.w[8] = ports;
         order_in.w[9] = 32'(proto);
         order_in.a    = sfkh_pkg::HASH_IV + sfkh_pkg::LEN_BYTES_V6 + seed_ff;
      end else begin
         order_in.w[0] = v4_src_first ? src[0] : dst[0];
         order_in.w[1] = v4_src_first ? dst[0] : src[0];
         order_in.w[2] = (form == sfkh_pkg::FORM_V4_PORTS) ? ports : sfkh_pkg::FIXED_PORTS;
         order_in.w[3] = 32'(proto);
         order_in.a    = sfkh_pkg::HASH_IV + sfkh_pkg::LEN_BYTES_V4 + seed_ff;
      end
      order_in.b = order_in.a;
      order_in.c = order_in.a;
   end

   // mix rounds and final stages
   always_comb begin
      for (int k = 1; k < sfkh_pkg::NUM_STAGES; k++) begin
         st_in[k] = st_ff[k-1];
         case (k)
            1: begin
               st_in[k] = sfkh_pkg::mix_lo(st_ff[k-1], st_ff[k-1].w[0], st_ff[k-1].w[1],
                                           st_ff[k-1].w[2]);
            end
            3: begin
               if (st_ff[k-1].v6) begin
                  st_in[k] = sfkh_pkg::mix_lo(st_ff[k-1], st_ff[k-1].w[3], st_ff[k-1].w[4],
                                              st_ff[k-1].w[5]);
               end
            end
            5: begin
               if (st_ff[k-1].v6) begin
                  st_in[k] = sfkh_pkg::mix_lo(st_ff[k-1], st_ff[k-1].w[6], st_ff[k-1].w[7],
                                              st_ff[k-1].w[8]);
               end
            end
            2: begin
               st_in[k] = sfkh_pkg::mix_hi(st_ff[k-1]);
            end
            4, 6: begin
               if (st_ff[k-1].v6) begin
                  st_in[k] = sfkh_pkg::mix_hi(st_ff[k-1]);
               end
            end
            7: begin
               st_in[k] = sfkh_pkg::fin_lo(st_ff[k-1],
                  st_ff[k-1].v6 ? st_ff[k-1].w[9] : st_ff[k-1].w[3]);
            end
            8: begin
               st_in[k] = sfkh_pkg::fin_hi(st_ff[k-1]);
            end
            default: begin
               st_in[k] = st_ff[k-1];
            end
         endcase
      end
   end

   // a stage takes a new beat when empty or when its contents move on
   always_comb begin
      adv[LAST] = !valid_ff[LAST] || rsp_tready;
      for (int k = LAST - 1; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff  <= '0;
         valid_ff <= '0;
      end else begin
         seed_ff <= seed_in;
         if (adv[0]) begin
            valid_ff[0] <= req_tvalid;
         end
         for (int k = 1; k < sfkh_pkg::NUM_STAGES; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0] && req_tvalid) begin
         st_ff[0] <= order_in;
      end
      for (int k = 1; k < sfkh_pkg::NUM_STAGES; k++) begin
         if (adv[k] && valid_ff[k-1]) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   assign req_tready = adv[0] && !reset;
   assign rsp_tvalid = valid_ff[LAST];
   assign rsp_tdata  = st_ff[LAST].c;

endmodule
